// ----- rtl/euler_to_quaternion_assert.svh -----
// Assertion macros for the euler_to_quaternion block.
// Depends on nothing; included by the top level.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// same-cycle implication
`define EUQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EUQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/euq_pkg.sv -----
// Constants and tables of the euler_to_quaternion block.
// Depends on nothing.
package euq_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int ZW = 34;
   localparam int SW = 32;
   localparam int PW = 34;
   localparam int QCW = 35;
   localparam int MW = 32;
   localparam int SQW = 64;
   localparam int RTW = 32;
   localparam int RW = 66;

   localparam logic signed [ZW-1:0] K_Q30 = 34'sd652032874;
   localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ZW-1:0] PI_HALF_Q30 = 34'sd1686629713;

   localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
      34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
      34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
      34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
      34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
      34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
   };

endpackage

// ----- rtl/euq_req_if.sv -----
// Request channel: one word of three angles with valid/ready.
// Depends on nothing.
interface euq_req_if #(parameter int ANGLE_WIDTH = 16) ();
   logic valid;
   logic ready;
   logic signed [ANGLE_WIDTH-1:0] angle_x;
   logic signed [ANGLE_WIDTH-1:0] angle_y;
   logic signed [ANGLE_WIDTH-1:0] angle_z;

   modport source (output valid, angle_x, angle_y, angle_z, input ready);
   modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

// ----- rtl/euq_rsp_if.sv -----
// Response channel: one word of four quaternion components with valid/ready.
// Depends on nothing.
interface euq_rsp_if #(parameter int QUAT_WIDTH = 16) ();
   logic valid;
   logic ready;
   logic signed [QUAT_WIDTH-1:0] quat_x;
   logic signed [QUAT_WIDTH-1:0] quat_y;
   logic signed [QUAT_WIDTH-1:0] quat_z;
   logic signed [QUAT_WIDTH-1:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ----- rtl/euler_to_quaternion.sv -----
// Euler angles to normalized quaternion, fully pipelined. Depends on euq_pkg,
// euq_req_if, euq_rsp_if and euler_to_quaternion_assert.svh.
//
// Accepts one word of three Q3.13 angles every cycle while the response side is not
// stalled and returns one word of four Q1.14 components per input, in order, through
// one capture stage, 30 CORDIC stages, sine/cosine, two product stages, sum, square,
// two add stages, 32 square-root stages, a numerator stage, QUAT_WIDTH-1 divider
// stages and the output register. A stall on the response side freezes the whole
// pipeline; nothing is lost or repeated.
`include "euler_to_quaternion_assert.svh"

module euler_to_quaternion
   import euq_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16,
   parameter int QUAT_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   euq_req_if.sink req,
   euq_rsp_if.source rsp
);

   localparam int HALF_SHIFT = 32 - ANGLE_WIDTH;
   localparam int DQ = QUAT_WIDTH - 1;
   localparam int DNW = MW + QUAT_WIDTH - 1;
   localparam logic [DQ-1:0] ONE_U = DQ'(1) << (QUAT_WIDTH - 2);
   localparam logic signed [QUAT_WIDTH-1:0] ONE_S = QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

   logic adv;
   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // capture and fold
   logic signed [ANGLE_WIDTH-1:0] ang [3];
   logic signed [31:0] half [3];
   logic signed [ZW-1:0] zin [3];
   logic fin [3];

   assign ang[0] = req.angle_x;
   assign ang[1] = req.angle_y;
   assign ang[2] = req.angle_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         half[k] = 32'(ang[k]) <<< HALF_SHIFT;
         zin[k] = ZW'(half[k]);
         fin[k] = 1'b0;
         if (zin[k] > PI_HALF_Q30) begin
            zin[k] = zin[k] - PI_Q30;
            fin[k] = 1'b1;
         end else if (zin[k] < -PI_HALF_Q30) begin
            zin[k] = zin[k] + PI_Q30;
            fin[k] = 1'b1;
         end
      end
   end

   logic cv_ff [CORDIC_STEPS+1];
   logic signed [ZW-1:0] cx_ff [CORDIC_STEPS+1][3];
   logic signed [ZW-1:0] cy_ff [CORDIC_STEPS+1][3];
   logic signed [ZW-1:0] cz_ff [CORDIC_STEPS+1][3];
   logic cf_ff [CORDIC_STEPS+1][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= req.valid;
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            cx_ff[0][k] <= K_Q30;
            cy_ff[0][k] <= '0;
            cz_ff[0][k] <= zin[k];
            cf_ff[0][k] <= fin[k];
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [ZW-1:0] x_in [3];
      logic signed [ZW-1:0] y_in [3];
      logic signed [ZW-1:0] z_in [3];

      always_comb begin
         for (int k = 0; k < 3; k++) begin
            if (cz_ff[i][k] >= 0) begin
               x_in[k] = cx_ff[i][k] - (cy_ff[i][k] >>> i);
               y_in[k] = cy_ff[i][k] + (cx_ff[i][k] >>> i);
               z_in[k] = cz_ff[i][k] - ATAN_Q30[i];
            end else begin
               x_in[k] = cx_ff[i][k] + (cy_ff[i][k] >>> i);
               y_in[k] = cy_ff[i][k] - (cx_ff[i][k] >>> i);
               z_in[k] = cz_ff[i][k] + ATAN_Q30[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
         if (adv) begin
            for (int k = 0; k < 3; k++) begin
               cx_ff[i+1][k] <= x_in[k];
               cy_ff[i+1][k] <= y_in[k];
               cz_ff[i+1][k] <= z_in[k];
               cf_ff[i+1][k] <= cf_ff[i][k];
            end
         end
      end
   end

   // sine and cosine
   logic sc_v_ff;
   logic signed [SW-1:0] sn_ff [3];
   logic signed [SW-1:0] cs_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
      end else if (adv) begin
         sc_v_ff <= cv_ff[CORDIC_STEPS];
      end
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sn_ff[k] <= cf_ff[CORDIC_STEPS][k] ? SW'(-cy_ff[CORDIC_STEPS][k])
                                                : SW'(cy_ff[CORDIC_STEPS][k]);
            cs_ff[k] <= cf_ff[CORDIC_STEPS][k] ? SW'(-cx_ff[CORDIC_STEPS][k])
                                                : SW'(cx_ff[CORDIC_STEPS][k]);
         end
      end
   end

   // pair products
   logic p1_v_ff;
   logic signed [PW-1:0] p1_ff [4];
   logic signed [SW-1:0] p1_sz_ff;
   logic signed [SW-1:0] p1_cz_ff;
   logic signed [63:0] m1 [4];

   always_comb begin
      m1[0] = cs_ff[0] * sn_ff[1];
      m1[1] = sn_ff[0] * cs_ff[1];
      m1[2] = cs_ff[0] * cs_ff[1];
      m1[3] = sn_ff[0] * sn_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= sc_v_ff;
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            p1_ff[k] <= PW'(m1[k] >>> 30);
         end
         p1_sz_ff <= sn_ff[2];
         p1_cz_ff <= cs_ff[2];
      end
   end

   // triple products
   logic p2_v_ff;
   logic signed [PW-1:0] p2_ff [8];
   logic signed [PW+SW-1:0] m2 [8];

   always_comb begin
      m2[0] = p1_ff[0] * p1_sz_ff;
      m2[1] = p1_ff[1] * p1_cz_ff;
      m2[2] = p1_ff[1] * p1_sz_ff;
      m2[3] = p1_ff[0] * p1_cz_ff;
      m2[4] = p1_ff[2] * p1_sz_ff;
      m2[5] = p1_ff[3] * p1_cz_ff;
      m2[6] = p1_ff[3] * p1_sz_ff;
      m2[7] = p1_ff[2] * p1_cz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (adv) begin
         p2_v_ff <= p1_v_ff;
      end
      if (adv) begin
         for (int k = 0; k < 8; k++) begin
            p2_ff[k] <= PW'(m2[k] >>> 30);
         end
      end
   end

   // components
   logic qv_ff;
   logic signed [QCW-1:0] q_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff <= 1'b0;
      end else if (adv) begin
         qv_ff <= p2_v_ff;
      end
      if (adv) begin
         q_ff[0] <= QCW'(p2_ff[0]) + QCW'(p2_ff[1]);
         q_ff[1] <= QCW'(p2_ff[3]) - QCW'(p2_ff[2]);
         q_ff[2] <= QCW'(p2_ff[4]) + QCW'(p2_ff[5]);
         q_ff[3] <= QCW'(p2_ff[7]) - QCW'(p2_ff[6]);
      end
   end

   // squares
   logic sq_v_ff;
   logic [SQW-1:0] sq_ff [4];
   logic [MW-1:0] sq_mag_ff [4];
   logic sq_sgn_ff [4];
   logic [MW-1:0] mag [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mag[k] = q_ff[k][QCW-1] ? MW'(-q_ff[k]) : MW'(q_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff <= qv_ff;
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            sq_ff[k] <= SQW'(mag[k]) * SQW'(mag[k]);
            sq_mag_ff[k] <= mag[k];
            sq_sgn_ff[k] <= q_ff[k][QCW-1];
         end
      end
   end

   // partial sums
   logic a1_v_ff;
   logic [SQW-1:0] s01_ff;
   logic [SQW-1:0] s23_ff;
   logic [MW-1:0] a1_mag_ff [4];
   logic a1_sgn_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff <= 1'b0;
      end else if (adv) begin
         a1_v_ff <= sq_v_ff;
      end
      if (adv) begin
         s01_ff <= sq_ff[0] + sq_ff[1];
         s23_ff <= sq_ff[2] + sq_ff[3];
         a1_mag_ff <= sq_mag_ff;
         a1_sgn_ff <= sq_sgn_ff;
      end
   end

   // square root, one result bit per stage
   logic rv_ff [RTW+1];
   logic [RW-1:0] rem_ff [RTW+1];
   logic [RTW-1:0] root_ff [RTW+1];
   logic [MW-1:0] r_mag_ff [RTW+1][4];
   logic r_sgn_ff [RTW+1][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (adv) begin
         rv_ff[0] <= a1_v_ff;
      end
      if (adv) begin
         rem_ff[0] <= RW'(s01_ff) + RW'(s23_ff);
         root_ff[0] <= '0;
         r_mag_ff[0] <= a1_mag_ff;
         r_sgn_ff[0] <= a1_sgn_ff;
      end
   end

   for (genvar j = 0; j < RTW; j++) begin : g_sqrt
      localparam int B = RTW - 1 - j;
      logic [RW-1:0] trial;
      logic take;

      assign trial = (RW'(root_ff[j]) << (B + 1)) + (RW'(1) << (2 * B));
      assign take = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            rv_ff[j+1] <= rv_ff[j];
         end
         if (adv) begin
            rem_ff[j+1] <= take ? rem_ff[j] - trial : rem_ff[j];
            root_ff[j+1] <= take ? (root_ff[j] | (RTW'(1) << B)) : root_ff[j];
            r_mag_ff[j+1] <= r_mag_ff[j];
            r_sgn_ff[j+1] <= r_sgn_ff[j];
         end
      end
   end

   // numerators, then restoring division, one quotient bit per stage
   logic dv_ff [DQ+1];
   logic [DNW-1:0] drem_ff [DQ+1][4];
   logic [DQ-1:0] dquo_ff [DQ+1][4];
   logic dsgn_ff [DQ+1][4];
   logic [RTW-1:0] dnorm_ff [DQ+1];
   logic dzero_ff [DQ+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= rv_ff[RTW];
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            drem_ff[0][k] <= (DNW'(r_mag_ff[RTW][k]) << (QUAT_WIDTH - 2))
                             + DNW'(root_ff[RTW] >> 1);
            dquo_ff[0][k] <= '0;
            dsgn_ff[0][k] <= r_sgn_ff[RTW][k];
         end
         dnorm_ff[0] <= root_ff[RTW];
         dzero_ff[0] <= root_ff[RTW] == '0;
      end
   end

   for (genvar j = 0; j < DQ; j++) begin : g_div
      localparam int B = DQ - 1 - j;
      logic [DNW-1:0] dvs;

      assign dvs = DNW'(dnorm_ff[j]) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (adv) begin
            for (int k = 0; k < 4; k++) begin
               if (drem_ff[j][k] >= dvs) begin
                  drem_ff[j+1][k] <= drem_ff[j][k] - dvs;
                  dquo_ff[j+1][k] <= dquo_ff[j][k] | (DQ'(1) << B);
               end else begin
                  drem_ff[j+1][k] <= drem_ff[j][k];
                  dquo_ff[j+1][k] <= dquo_ff[j][k];
               end
               dsgn_ff[j+1][k] <= dsgn_ff[j][k];
            end
            dnorm_ff[j+1] <= dnorm_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
         end
      end
   end

   // saturate, sign and drive the output word; a zero norm gives the identity quaternion
   logic out_v_ff;
   logic signed [QUAT_WIDTH-1:0] out_ff [4];
   logic [DQ-1:0] qsat [4];
   logic signed [QUAT_WIDTH-1:0] res [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qsat[k] = (dquo_ff[DQ][k] > ONE_U) ? ONE_U : dquo_ff[DQ][k];
         res[k] = dsgn_ff[DQ][k] ? -QUAT_WIDTH'({1'b0, qsat[k]})
                                 : QUAT_WIDTH'({1'b0, qsat[k]});
         if (dzero_ff[DQ]) begin
            res[k] = (k == 3) ? ONE_S : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[DQ];
      end
      if (adv) begin
         out_ff <= res;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.quat_x = out_ff[0];
   assign rsp.quat_y = out_ff[1];
   assign rsp.quat_z = out_ff[2];
   assign rsp.quat_w = out_ff[3];

   `EUQ_ASSERT_NOW(a_sqrt_rem, clock, reset, rv_ff[RTW], rem_ff[RTW] <= RW'({root_ff[RTW], 1'b0}), "square root remainder out of range")
   `EUQ_ASSERT_NOW(a_mag_le_norm, clock, reset, rv_ff[RTW], r_mag_ff[RTW][0] <= root_ff[RTW] && r_mag_ff[RTW][3] <= root_ff[RTW], "component exceeds norm")
   `EUQ_ASSERT_NOW(a_w_range, clock, reset, rsp.valid, rsp.quat_w <= ONE_S && rsp.quat_w >= -ONE_S, "quat_w out of range")
   `EUQ_ASSERT_NEXT(a_stall_hold, clock, reset, rsp.valid && !rsp.ready, $stable(out_ff[0]) && $stable(dv_ff[DQ]), "pipeline moved during stall")

endmodule
